// ===== rtl/tfhs_pkg.sv =====
`timescale 1ns / 1ps
package tfhs_pkg;

  // Widths of the datapath words.
  localparam int CW    = 16;  // coordinates and query point
  localparam int DW    = 18;  // vertex and point differences
  localparam int NW    = 36;  // normal components and edge products
  localparam int SW    = 28;  // normal components after range reduction
  localparam int PW    = 64;  // products and sums of products
  localparam int RW    = 58;  // remainder of the normal Y fraction
  localparam int FW    = 31;  // normal Y squared fraction, Q.30
  localparam int QSW   = 32;  // square root working registers
  localparam int QW    = 62;  // magnitude of the height dividend
  localparam int DRW   = NW + 1;
  localparam int HW    = 24;
  localparam int CNTW  = 6;
  localparam int STEPW = 5;
  localparam int SFTW  = 5;
  localparam int NORM_BITS = 27;

  // Sequencer counts.
  localparam logic [CNTW-1:0] MULA_LAST  = 6'd14;
  localparam logic [CNTW-1:0] MULB_FIRST = 6'd15;
  localparam logic [CNTW-1:0] MULB_LAST  = 6'd17;
  localparam logic [CNTW-1:0] FRAC_LAST  = 6'd29;
  localparam logic [CNTW-1:0] SQRT_LAST  = 6'd15;
  localparam logic [CNTW-1:0] DIV_LAST   = 6'(QW - 1);
  localparam logic [SFTW-1:0] SHIFT_MAX  = 5'd16;

  // Fixed constants of the query.
  localparam logic signed [HW-1:0] NONE_HEIGHT_Q8 = -24'sd7680000;
  localparam logic [15:0]          ONE_Q15        = 16'd32768;
  localparam logic signed [PW-1:0] HEIGHT_MAX_Q8  = 64'sd8388607;
  localparam logic signed [DW-1:0] ABOVE_LIMIT    = 18'sd120;
  localparam logic signed [DW-1:0] BELOW_LIMIT    = 18'sd78;
  localparam logic [PW-1:0]        WALL_NUM       = 64'd100;
  localparam logic [PW-1:0]        WALL_DEN       = 64'd9;
  localparam logic [FW-1:0]        FRAC_FULL      = 31'h4000_0000;
  localparam logic [QSW-1:0]       SQRT_ONE_INIT  = 32'h4000_0000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POINT_X = 2'd0;
  localparam logic [1:0] CFG_POINT_Y = 2'd1;
  localparam logic [1:0] CFG_POINT_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MULA, ST_PREP, ST_SHIFT, ST_MULB, ST_DRAIN,
    ST_FRAC, ST_SQI, ST_SQRT, ST_DVI, ST_DIV, ST_DECIDE
  } state_t;

  typedef enum logic [3:0] {
    A_E1X, A_E1Y, A_E1Z, A_DAZ, A_DAX, A_DBZ, A_DBX, A_DCZ, A_DCX,
    A_NX, A_NY, A_NZ, A_SX, A_SY, A_SZ
  } asel_t;

  typedef enum logic [3:0] {
    B_E1X, B_E1Z, B_E2X, B_E2Y, B_E2Z, B_E3X, B_E3Z, B_DAX, B_DAZ, B_DLY,
    B_SX, B_SY, B_SZ
  } bsel_t;

  typedef enum logic [3:0] {
    D_NONE, D_NX, D_NY, D_NZ, D_E0, D_E1, D_E2, D_NUM, D_LIM, D_SQ, D_SQY
  } dest_t;

  typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} accop_t;

  typedef struct packed {
    logic   en;
    asel_t  a_sel;
    bsel_t  b_sel;
    dest_t  dest;
    accop_t op;
  } mul_cmd_t;

  typedef struct packed {
    logic     load_in;
    logic     diff;
    logic     prep;
    logic     shift;
    logic     frac_init;
    logic     frac_step;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     decide;
    mul_cmd_t mul;
  } dp_cmd_t;

  typedef struct packed {
    logic shift_more;
    logic last;
    logic out_busy;
  } dp_stat_t;

  // Multiply program: one product per step, summed in the following cycle.
  function automatic mul_cmd_t mul_prog(input logic [STEPW-1:0] step);
    mul_cmd_t c;
    c = '{en: 1'b1, a_sel: A_E1X, b_sel: B_E1X, dest: D_NONE, op: OP_LOAD};
    case (step)
      5'd0:  begin c.a_sel = A_E1Y; c.b_sel = B_E2Z; c.dest = D_NX;  c.op = OP_LOAD; end
      5'd1:  begin c.a_sel = A_E1Z; c.b_sel = B_E2Y; c.dest = D_NX;  c.op = OP_SUB;  end
      5'd2:  begin c.a_sel = A_E1Z; c.b_sel = B_E2X; c.dest = D_NY;  c.op = OP_LOAD; end
      5'd3:  begin c.a_sel = A_E1X; c.b_sel = B_E2Z; c.dest = D_NY;  c.op = OP_SUB;  end
      5'd4:  begin c.a_sel = A_E1X; c.b_sel = B_E2Y; c.dest = D_NZ;  c.op = OP_LOAD; end
      5'd5:  begin c.a_sel = A_E1Y; c.b_sel = B_E2X; c.dest = D_NZ;  c.op = OP_SUB;  end
      5'd6:  begin c.a_sel = A_DAZ; c.b_sel = B_E1X; c.dest = D_E0;  c.op = OP_LOAD; end
      5'd7:  begin c.a_sel = A_DAX; c.b_sel = B_E1Z; c.dest = D_E0;  c.op = OP_SUB;  end
      5'd8:  begin c.a_sel = A_DBZ; c.b_sel = B_E2X; c.dest = D_E1;  c.op = OP_LOAD; end
      5'd9:  begin c.a_sel = A_DBX; c.b_sel = B_E2Z; c.dest = D_E1;  c.op = OP_SUB;  end
      5'd10: begin c.a_sel = A_DCZ; c.b_sel = B_E3X; c.dest = D_E2;  c.op = OP_LOAD; end
      5'd11: begin c.a_sel = A_DCX; c.b_sel = B_E3Z; c.dest = D_E2;  c.op = OP_SUB;  end
      5'd12: begin c.a_sel = A_NX;  c.b_sel = B_DAX; c.dest = D_NUM; c.op = OP_LOAD; end
      5'd13: begin c.a_sel = A_NZ;  c.b_sel = B_DAZ; c.dest = D_NUM; c.op = OP_ADD;  end
      5'd14: begin c.a_sel = A_NY;  c.b_sel = B_DLY; c.dest = D_LIM; c.op = OP_LOAD; end
      5'd15: begin c.a_sel = A_SX;  c.b_sel = B_SX;  c.dest = D_SQ;  c.op = OP_LOAD; end
      5'd16: begin c.a_sel = A_SY;  c.b_sel = B_SY;  c.dest = D_SQY; c.op = OP_ADD;  end
      5'd17: begin c.a_sel = A_SZ;  c.b_sel = B_SZ;  c.dest = D_SQ;  c.op = OP_ADD;  end
      default: c.en = 1'b0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tfhs_ctrl.sv =====
`timescale 1ns / 1ps
module tfhs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tfhs_pkg::dp_stat_t stat,
  output tfhs_pkg::dp_cmd_t  cmd
);

  tfhs_pkg::state_t            state_r, state_nxt;
  logic [tfhs_pkg::CNTW-1:0]   cnt_r, cnt_nxt;

  // State and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfhs_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencing of one triangle through the shared multiplier and the iterative units.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      tfhs_pkg::ST_IDLE: begin
        // Nothing is taken while reset is held.
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load_in = 1'b1;
          state_nxt   = tfhs_pkg::ST_DIFF;
        end
      end
      tfhs_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = tfhs_pkg::ST_MULA;
      end
      tfhs_pkg::ST_MULA: begin
        cmd.mul = tfhs_pkg::mul_prog(cnt_r[tfhs_pkg::STEPW-1:0]);
        if (cnt_r == tfhs_pkg::MULA_LAST) state_nxt = tfhs_pkg::ST_PREP;
        else cnt_nxt = cnt_r + 1'b1;
      end
      tfhs_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = tfhs_pkg::ST_SHIFT;
      end
      tfhs_pkg::ST_SHIFT: begin
        if (stat.shift_more) begin
          cmd.shift = 1'b1;
        end else begin
          cnt_nxt   = tfhs_pkg::MULB_FIRST;
          state_nxt = tfhs_pkg::ST_MULB;
        end
      end
      tfhs_pkg::ST_MULB: begin
        cmd.mul = tfhs_pkg::mul_prog(cnt_r[tfhs_pkg::STEPW-1:0]);
        if (cnt_r == tfhs_pkg::MULB_LAST) state_nxt = tfhs_pkg::ST_DRAIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      tfhs_pkg::ST_DRAIN: begin
        cmd.frac_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = tfhs_pkg::ST_FRAC;
      end
      tfhs_pkg::ST_FRAC: begin
        cmd.frac_step = 1'b1;
        if (cnt_r == tfhs_pkg::FRAC_LAST) state_nxt = tfhs_pkg::ST_SQI;
        else cnt_nxt = cnt_r + 1'b1;
      end
      tfhs_pkg::ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = tfhs_pkg::ST_SQRT;
      end
      tfhs_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == tfhs_pkg::SQRT_LAST) state_nxt = tfhs_pkg::ST_DVI;
        else cnt_nxt = cnt_r + 1'b1;
      end
      tfhs_pkg::ST_DVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = tfhs_pkg::ST_DIV;
      end
      tfhs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == tfhs_pkg::DIV_LAST) state_nxt = tfhs_pkg::ST_DECIDE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      tfhs_pkg::ST_DECIDE: begin
        // A final triangle waits here until the output register is free.
        if (!(stat.last && stat.out_busy)) begin
          cmd.decide = 1'b1;
          state_nxt  = tfhs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfhs_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == tfhs_pkg::ST_DIFF))
    else $error("accepted transaction did not start processing");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfhs_pkg::ST_DECIDE && stat.last && stat.out_busy)
      |=> (state_r == tfhs_pkg::ST_DECIDE))
    else $error("result dropped while output register was full");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfhs_pkg::ST_DIV) |-> (cnt_r <= tfhs_pkg::DIV_LAST))
    else $error("divider step count overran");
`endif

endmodule

// ===== rtl/tfhs_dp.sv =====
`timescale 1ns / 1ps
module tfhs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic [159:0]       in_tdata,
  input  logic               in_tlast,
  input  tfhs_pkg::dp_cmd_t  cmd,
  output tfhs_pkg::dp_stat_t stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [55:0]        out_tdata
);

  localparam int CW  = tfhs_pkg::CW;
  localparam int DW  = tfhs_pkg::DW;
  localparam int NW  = tfhs_pkg::NW;
  localparam int SW  = tfhs_pkg::SW;
  localparam int PW  = tfhs_pkg::PW;
  localparam int RW  = tfhs_pkg::RW;
  localparam int FW  = tfhs_pkg::FW;
  localparam int QSW = tfhs_pkg::QSW;
  localparam int QW  = tfhs_pkg::QW;
  localparam int DRW = tfhs_pkg::DRW;
  localparam int HW  = tfhs_pkg::HW;

  logic signed [CW-1:0] px_r, py_r, pz_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic [15:0]          flags_r;
  logic                 last_r;
  logic signed [DW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, e3x_r, e3z_r;
  logic signed [DW-1:0] dax_r, daz_r, dbx_r, dbz_r, dcx_r, dcz_r, dly_r;
  logic signed [PW-1:0] p_r;
  tfhs_pkg::mul_cmd_t   mq_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r, e0_r, e1_r, e2_r;
  logic signed [PW-1:0] num_r, lim_r;
  logic [PW-1:0]        sq_r, ysq_r;
  logic [NW-1:0]        m_r;
  logic signed [NW-1:0] sx_r, sy_r, sz_r;
  logic [tfhs_pkg::SFTW-1:0] s_r;
  logic [RW-1:0]        rem_r;
  logic [FW-1:0]        frac_r;
  logic [QSW-1:0]       sop_r, sres_r, sone_r;
  logic [QW-1:0]        dq_r;
  logic [DRW-1:0]       drem_r;
  logic                 dneg_r;
  logic signed [HW-1:0] best_h_r;
  logic [15:0]          best_n_r, best_f_r;
  logic                 out_valid_r;
  logic [55:0]          out_data_r;

  logic signed [NW-1:0] mul_a;
  logic signed [SW-1:0] mul_b;
  logic signed [PW-1:0] acc_cur, acc_sum;
  logic [NW-1:0]        abs_x, abs_y, abs_z, max_xy, max_all;
  logic [RW-1:0]        frac_t;
  logic [QSW-1:0]       sq_trial;
  logic [DRW-1:0]       div_t;
  logic [PW-1:0]        num_mag;
  logic signed [PW-1:0] q_mag, q_s, h_raw, h_val;
  logic signed [DW-1:0] lim_hi, lim_lo;
  logic                 degen, wall, too_high, outside, below, cand, take;
  logic [15:0]          unit_y;
  logic signed [HW-1:0] nb_h;
  logic [15:0]          nb_n, nb_f;

  // Query point registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      pz_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == tfhs_pkg::CFG_POINT_X) px_r <= $signed(cfg_wdata);
      if (cfg_addr == tfhs_pkg::CFG_POINT_Y) py_r <= $signed(cfg_wdata);
      if (cfg_addr == tfhs_pkg::CFG_POINT_Z) pz_r <= $signed(cfg_wdata);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd.mul.a_sel)
      tfhs_pkg::A_E1X: mul_a = NW'(e1x_r);
      tfhs_pkg::A_E1Y: mul_a = NW'(e1y_r);
      tfhs_pkg::A_E1Z: mul_a = NW'(e1z_r);
      tfhs_pkg::A_DAZ: mul_a = NW'(daz_r);
      tfhs_pkg::A_DAX: mul_a = NW'(dax_r);
      tfhs_pkg::A_DBZ: mul_a = NW'(dbz_r);
      tfhs_pkg::A_DBX: mul_a = NW'(dbx_r);
      tfhs_pkg::A_DCZ: mul_a = NW'(dcz_r);
      tfhs_pkg::A_DCX: mul_a = NW'(dcx_r);
      tfhs_pkg::A_NX:  mul_a = nx_r;
      tfhs_pkg::A_NY:  mul_a = ny_r;
      tfhs_pkg::A_NZ:  mul_a = nz_r;
      tfhs_pkg::A_SX:  mul_a = sx_r;
      tfhs_pkg::A_SY:  mul_a = sy_r;
      tfhs_pkg::A_SZ:  mul_a = sz_r;
      default:         mul_a = '0;
    endcase
    case (cmd.mul.b_sel)
      tfhs_pkg::B_E1X: mul_b = SW'(e1x_r);
      tfhs_pkg::B_E1Z: mul_b = SW'(e1z_r);
      tfhs_pkg::B_E2X: mul_b = SW'(e2x_r);
      tfhs_pkg::B_E2Y: mul_b = SW'(e2y_r);
      tfhs_pkg::B_E2Z: mul_b = SW'(e2z_r);
      tfhs_pkg::B_E3X: mul_b = SW'(e3x_r);
      tfhs_pkg::B_E3Z: mul_b = SW'(e3z_r);
      tfhs_pkg::B_DAX: mul_b = SW'(dax_r);
      tfhs_pkg::B_DAZ: mul_b = SW'(daz_r);
      tfhs_pkg::B_DLY: mul_b = SW'(dly_r);
      tfhs_pkg::B_SX:  mul_b = $signed(sx_r[SW-1:0]);
      tfhs_pkg::B_SY:  mul_b = $signed(sy_r[SW-1:0]);
      tfhs_pkg::B_SZ:  mul_b = $signed(sz_r[SW-1:0]);
      default:         mul_b = '0;
    endcase
  end

  // Accumulation of the product registered in the previous cycle.
  always_comb begin
    case (mq_r.dest)
      tfhs_pkg::D_NX:  acc_cur = PW'(nx_r);
      tfhs_pkg::D_NY:  acc_cur = PW'(ny_r);
      tfhs_pkg::D_NZ:  acc_cur = PW'(nz_r);
      tfhs_pkg::D_E0:  acc_cur = PW'(e0_r);
      tfhs_pkg::D_E1:  acc_cur = PW'(e1_r);
      tfhs_pkg::D_E2:  acc_cur = PW'(e2_r);
      tfhs_pkg::D_NUM: acc_cur = num_r;
      tfhs_pkg::D_LIM: acc_cur = lim_r;
      tfhs_pkg::D_SQ,
      tfhs_pkg::D_SQY: acc_cur = $signed(sq_r);
      default:         acc_cur = '0;
    endcase
    case (mq_r.op)
      tfhs_pkg::OP_ADD: acc_sum = acc_cur + p_r;
      tfhs_pkg::OP_SUB: acc_sum = acc_cur - p_r;
      default:          acc_sum = p_r;
    endcase
  end

  // Largest normal component magnitude, for range reduction.
  always_comb begin
    abs_x   = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    abs_y   = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    abs_z   = nz_r[NW-1] ? NW'(-nz_r) : NW'(nz_r);
    max_xy  = (abs_y > abs_x) ? abs_y : abs_x;
    max_all = (abs_z > max_xy) ? abs_z : max_xy;
  end

  // One step of each iterative unit.
  always_comb begin
    frac_t   = {rem_r[RW-2:0], 1'b0};
    sq_trial = sres_r + sone_r;
    div_t    = {drem_r[DRW-2:0], dq_r[QW-1]};
    num_mag  = num_r[PW-1] ? PW'(-num_r) : PW'(num_r);
  end

  // Floor of the signed height quotient and the candidate height.
  always_comb begin
    q_mag = $signed(PW'(dq_r));
    q_s   = dneg_r ? (-q_mag - ((drem_r != '0) ? 64'sd1 : 64'sd0)) : q_mag;
    h_raw = (PW'(ay_r) <<< 8) + q_s;
    if (degen) h_val = '0;
    else if (h_raw > tfhs_pkg::HEIGHT_MAX_Q8) h_val = tfhs_pkg::HEIGHT_MAX_Q8;
    else h_val = h_raw;
  end

  // Floor tests and the updated best values.
  always_comb begin
    degen    = (nx_r == '0) && (ny_r == '0) && (nz_r == '0);
    wall     = !degen && (sy_r[NW-1] ||
               ((ysq_r * tfhs_pkg::WALL_NUM) < (sq_r * tfhs_pkg::WALL_DEN)));
    lim_hi   = DW'(py_r) + tfhs_pkg::ABOVE_LIMIT;
    lim_lo   = DW'(py_r) + tfhs_pkg::BELOW_LIMIT;
    too_high = (lim_hi < DW'(ay_r)) && (lim_hi < DW'(by_r)) && (lim_hi < DW'(cy_r));
    outside  = e0_r[NW-1] || e1_r[NW-1] || e2_r[NW-1];
    below    = degen ? lim_lo[DW-1] : (num_r > lim_r);
    cand     = !wall && !too_high && !outside && !below;
    unit_y   = degen ? tfhs_pkg::ONE_Q15 : sres_r[15:0];
    take     = cand && (h_val > PW'(best_h_r));
    nb_h     = take ? h_val[HW-1:0] : best_h_r;
    nb_n     = take ? unit_y : best_n_r;
    nb_f     = take ? flags_r : best_f_r;
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ax_r    <= $signed(in_tdata[15:0]);
      ay_r    <= $signed(in_tdata[31:16]);
      az_r    <= $signed(in_tdata[47:32]);
      bx_r    <= $signed(in_tdata[63:48]);
      by_r    <= $signed(in_tdata[79:64]);
      bz_r    <= $signed(in_tdata[95:80]);
      cx_r    <= $signed(in_tdata[111:96]);
      cy_r    <= $signed(in_tdata[127:112]);
      cz_r    <= $signed(in_tdata[143:128]);
      flags_r <= in_tdata[159:144];
      last_r  <= in_tlast;
    end
    if (cmd.diff) begin
      e1x_r <= DW'(bx_r) - DW'(ax_r);
      e1y_r <= DW'(by_r) - DW'(ay_r);
      e1z_r <= DW'(bz_r) - DW'(az_r);
      e2x_r <= DW'(cx_r) - DW'(bx_r);
      e2y_r <= DW'(cy_r) - DW'(by_r);
      e2z_r <= DW'(cz_r) - DW'(bz_r);
      e3x_r <= DW'(ax_r) - DW'(cx_r);
      e3z_r <= DW'(az_r) - DW'(cz_r);
      dax_r <= DW'(ax_r) - DW'(px_r);
      daz_r <= DW'(az_r) - DW'(pz_r);
      dbx_r <= DW'(bx_r) - DW'(px_r);
      dbz_r <= DW'(bz_r) - DW'(pz_r);
      dcx_r <= DW'(cx_r) - DW'(px_r);
      dcz_r <= DW'(cz_r) - DW'(pz_r);
      dly_r <= DW'(py_r) + tfhs_pkg::BELOW_LIMIT - DW'(ay_r);
    end
    p_r <= PW'(mul_a * mul_b);
    if (mq_r.en) begin
      case (mq_r.dest)
        tfhs_pkg::D_NX:  nx_r  <= acc_sum[NW-1:0];
        tfhs_pkg::D_NY:  ny_r  <= acc_sum[NW-1:0];
        tfhs_pkg::D_NZ:  nz_r  <= acc_sum[NW-1:0];
        tfhs_pkg::D_E0:  e0_r  <= acc_sum[NW-1:0];
        tfhs_pkg::D_E1:  e1_r  <= acc_sum[NW-1:0];
        tfhs_pkg::D_E2:  e2_r  <= acc_sum[NW-1:0];
        tfhs_pkg::D_NUM: num_r <= acc_sum;
        tfhs_pkg::D_LIM: lim_r <= acc_sum;
        tfhs_pkg::D_SQ:  sq_r  <= acc_sum;
        tfhs_pkg::D_SQY: begin
          sq_r  <= acc_sum;
          ysq_r <= p_r;
        end
        default: ;
      endcase
    end
    // Range reduction: halve the normal until it fits the square unit.
    if (cmd.prep) begin
      sx_r <= nx_r;
      sy_r <= ny_r;
      sz_r <= nz_r;
      m_r  <= max_all;
      s_r  <= '0;
    end else if (cmd.shift) begin
      sx_r <= sx_r >>> 1;
      sy_r <= sy_r >>> 1;
      sz_r <= sz_r >>> 1;
      m_r  <= m_r >> 1;
      s_r  <= s_r + 1'b1;
    end
    // Normal Y squared over length squared, one bit a cycle.
    if (cmd.frac_init) begin
      rem_r  <= RW'(ysq_r);
      frac_r <= '0;
    end else if (cmd.frac_step) begin
      if (frac_t >= RW'(sq_r)) begin
        rem_r  <= frac_t - RW'(sq_r);
        frac_r <= {frac_r[FW-2:0], 1'b1};
      end else begin
        rem_r  <= frac_t;
        frac_r <= {frac_r[FW-2:0], 1'b0};
      end
    end
    // Integer square root, one result bit a cycle.
    if (cmd.sqrt_init) begin
      sop_r  <= ((rem_r == '0) && (ysq_r == sq_r)) ? QSW'(tfhs_pkg::FRAC_FULL)
                                                    : QSW'(frac_r);
      sres_r <= '0;
      sone_r <= tfhs_pkg::SQRT_ONE_INIT;
    end else if (cmd.sqrt_step) begin
      if (sop_r >= sq_trial) begin
        sop_r  <= sop_r - sq_trial;
        sres_r <= (sres_r >> 1) + sone_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sone_r <= sone_r >> 2;
    end
    // Height quotient: magnitude of num * 256 over normal Y.
    if (cmd.div_init) begin
      dq_r   <= QW'(num_mag << 8);
      drem_r <= '0;
      dneg_r <= num_r[PW-1];
    end else if (cmd.div_step) begin
      if (div_t >= DRW'(ny_r)) begin
        drem_r <= div_t - DRW'(ny_r);
        dq_r   <= {dq_r[QW-2:0], 1'b1};
      end else begin
        drem_r <= div_t;
        dq_r   <= {dq_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.decide && last_r) out_data_r <= {nb_f, nb_n, nb_h};
  end

  // Best floor, pending multiply command and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mq_r        <= '0;
      best_h_r    <= tfhs_pkg::NONE_HEIGHT_Q8;
      best_n_r    <= tfhs_pkg::ONE_Q15;
      best_f_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mq_r <= cmd.mul;
      if (cmd.decide) begin
        if (last_r) begin
          best_h_r <= tfhs_pkg::NONE_HEIGHT_Q8;
          best_n_r <= tfhs_pkg::ONE_Q15;
          best_f_r <= '0;
        end else begin
          best_h_r <= nb_h;
          best_n_r <= nb_n;
          best_f_r <= nb_f;
        end
      end
      if (cmd.decide && last_r) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.shift_more = (m_r[NW-1:tfhs_pkg::NORM_BITS] != '0) && (s_r != tfhs_pkg::SHIFT_MAX);
    stat.last       = last_r;
    stat.out_busy   = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/triangle_floor_height_search.sv =====
`timescale 1ns / 1ps
// Floor height query over a stream of triangles.
// The query point is written through the cfg_ port (index 0: X, 1: Y, 2: Z)
// by the user only while the block is idle; the block itself does not enforce
// it. Each transaction on the in_ channel carries one triangle; in_tlast marks
// the final triangle of a query. After the final triangle one transaction
// leaves on the out_ channel with the highest floor found (or the "none" values)
// and the kept floor is cleared for the next query. For each triangle a single
// shared multiplier runs eighteen products, then a one-bit-per-cycle fraction
// unit, a square root unit and a restoring divider run in turn. in_tready is
// high only between triangles: no new triangle is taken until the last is done.
// The result appears on out_tvalid the cycle after the final triangle is done
// and is held in an output register; the next query's triangles are accepted
// while it waits. If a second result is due while the first is still stalled
// by out_tready, the block holds that triangle until the register frees.
// Reset (rst_n low, synchronous) clears the query point to zero, the kept
// floor to its "none" values and drops any pending result.
module triangle_floor_height_search (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, surface_flags
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // floor_height, floor_normal_y, floor_flags
  output logic [55:0]  out_tdata
);

  tfhs_pkg::dp_cmd_t  cmd;
  tfhs_pkg::dp_stat_t stat;

  tfhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfhs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
